FILE: src/wfts_pkg.sv
package wfts_pkg;

    // Fixed widths of the accumulators, the window length register and the result fields.
    localparam int unsigned ACC_W      = 32;
    localparam int unsigned CFG_W      = 16;
    localparam int unsigned WORST_US_W = 22;

    // Scale factors applied before each divide (products wrap at ACC_W bits).
    localparam logic [ACC_W-1:0] FPS_SCALE = 32'd10000;
    localparam logic [ACC_W-1:0] US_PER_MS = 32'd1000;

    // Reset value of the window length register.
    localparam logic [CFG_W-1:0] WINDOW_RESET = 16'd1000;

    // The shared divider retires one quotient bit per cycle.
    localparam int unsigned DIV_STEPS = ACC_W;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Which of the three divides is in progress.
    typedef enum logic [1:0] {
        OP_FPS = 2'd0,
        OP_MFR = 2'd1,
        OP_MWK = 2'd2
    } t_op;

    typedef struct packed {
        logic acc_en;     // accumulate the accepted frame report
        logic mul_load;   // scale the operand and load it into the divider
        logic store_q;    // capture the finished quotient
        logic load_out;   // copy the results into the output register
        logic clr_acc;    // clear all window accumulators
        t_op  op;         // selects operand, divisor and result slot
    } t_dp_cmd;

    typedef struct packed {
        logic win_closed; // accumulated time reached the window length
        logic div_done;   // divider has no steps left
    } t_dp_sts;

endpackage

FILE: src/wfts_ctrl.sv
module wfts_ctrl
    import wfts_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_DIV,
        S_WRITE
    } t_state;

    t_state r_state;
    t_op    r_op;
    logic   r_out_valid;
    logic   slot_free;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.op       = r_op;
        o_cmd.acc_en   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.mul_load = (r_state == S_MUL);
        o_cmd.store_q  = (r_state == S_DIV) && i_sts.div_done;
        o_cmd.load_out = (r_state == S_WRITE) && slot_free;
        o_cmd.clr_acc  = (r_state == S_WRITE) && slot_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_FPS;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_op <= OP_FPS;
                    if (i_sts.win_closed) begin
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_MUL: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (i_sts.div_done) begin
                        unique case (r_op)
                            OP_FPS: begin
                                r_op    <= OP_MFR;
                                r_state <= S_MUL;
                            end
                            OP_MFR: begin
                                r_op    <= OP_MWK;
                                r_state <= S_MUL;
                            end
                            default: begin
                                r_state <= S_WRITE;
                            end
                        endcase
                    end
                end
                S_WRITE: begin
                    if (slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: src/wfts_dp.sv
module wfts_dp
    import wfts_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_W-1:0]       i_cfg_wdata,
    input  logic [SAMPLE_BITS-1:0] i_frame_ms,
    input  logic [SAMPLE_BITS-1:0] i_work_ms,
    input  t_dp_cmd                i_cmd,
    output t_dp_sts                o_sts,
    output logic [ACC_W-1:0]       o_fps_tenths,
    output logic [ACC_W-1:0]       o_mean_frame_us,
    output logic [ACC_W-1:0]       o_mean_work_us,
    output logic [WORST_US_W-1:0]  o_worst_work_us,
    output logic [ACC_W-1:0]       o_frame_count
);

    logic [CFG_W-1:0]       r_window_len;
    logic [ACC_W-1:0]       r_time;
    logic [ACC_W-1:0]       r_frames;
    logic [ACC_W-1:0]       r_work;
    logic [SAMPLE_BITS-1:0] r_worst;

    logic [ACC_W-1:0]       r_quo;
    logic [ACC_W-1:0]       r_rem;
    logic [ACC_W-1:0]       r_den;
    logic [DIV_CNT_W-1:0]   r_cnt;

    logic [ACC_W-1:0]       r_fps;
    logic [ACC_W-1:0]       r_mfr;
    logic [ACC_W-1:0]       r_mwk;

    logic [ACC_W-1:0]       mul_a;
    logic [ACC_W-1:0]       mul_k;
    logic [ACC_W-1:0]       product;
    logic [ACC_W-1:0]       divisor;
    logic [ACC_W:0]         trial;
    logic [ACC_W:0]         diff;
    logic [ACC_W-1:0]       quotient;
    logic [ACC_W-1:0]       worst_scaled;

    always_comb begin
        unique case (i_cmd.op)
            OP_FPS: begin
                mul_a   = r_frames;
                mul_k   = FPS_SCALE;
                divisor = r_time;
            end
            OP_MFR: begin
                mul_a   = r_time;
                mul_k   = US_PER_MS;
                divisor = r_frames;
            end
            default: begin
                mul_a   = r_work;
                mul_k   = US_PER_MS;
                divisor = r_frames;
            end
        endcase
    end

    // Low word of the product only: the scaled value wraps like the accumulators.
    assign product  = mul_a * mul_k;
    assign trial    = {r_rem, r_quo[ACC_W-1]};
    assign diff     = trial - {1'b0, r_den};
    // A zero divisor yields a zero quotient.
    assign quotient = (r_den == '0) ? '0 : r_quo;
    assign worst_scaled = ACC_W'(r_worst) * US_PER_MS;

    assign o_sts.win_closed = (r_time >= ACC_W'(r_window_len));
    assign o_sts.div_done   = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= WINDOW_RESET;
            r_time       <= '0;
            r_frames     <= '0;
            r_work       <= '0;
            r_worst      <= '0;
            r_cnt        <= '0;
        end else begin
            if (i_cfg_we) begin
                r_window_len <= i_cfg_wdata;
            end

            if (i_cmd.clr_acc) begin
                r_time   <= '0;
                r_frames <= '0;
                r_work   <= '0;
                r_worst  <= '0;
            end else if (i_cmd.acc_en) begin
                r_time   <= r_time + ACC_W'(i_frame_ms);
                r_frames <= r_frames + ACC_W'(1);
                r_work   <= r_work + ACC_W'(i_work_ms);
                if (i_work_ms > r_worst) begin
                    r_worst <= i_work_ms;
                end
            end

            if (i_cmd.mul_load) begin
                r_cnt <= DIV_CNT_W'(DIV_STEPS);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
            end
        end
    end

    // Restoring divider: one quotient bit per cycle, numerator shifts out of r_quo.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_load) begin
            r_quo <= product;
            r_rem <= '0;
            r_den <= divisor;
        end else if (r_cnt != '0) begin
            if (!diff[ACC_W]) begin
                r_rem <= diff[ACC_W-1:0];
                r_quo <= {r_quo[ACC_W-2:0], 1'b1};
            end else begin
                r_rem <= trial[ACC_W-1:0];
                r_quo <= {r_quo[ACC_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store_q) begin
            unique case (i_cmd.op)
                OP_FPS:  r_fps <= quotient;
                OP_MFR:  r_mfr <= quotient;
                default: r_mwk <= quotient;
            endcase
        end
        if (i_cmd.load_out) begin
            o_fps_tenths    <= r_fps;
            o_mean_frame_us <= r_mfr;
            o_mean_work_us  <= r_mwk;
            o_worst_work_us <= worst_scaled[WORST_US_W-1:0];
            o_frame_count   <= r_frames;
        end
    end

endmodule

FILE: src/windowed_frame_time_stats_top.sv
// A frame report that does not close the window is absorbed and the controller
// returns to idle; one that closes it yields its result transaction after three
// scale-and-divide passes through one shared divider. The block takes no new report
// until it is done with the last, which includes waiting for a free output slot.
// Reset (i_rst_n, synchronous, active low) clears the accumulators and the output
// valid, and sets the window length to 1000 ms.
module windowed_frame_time_stats_top
    import wfts_pkg::*;
#(
    // Width of the frame and work time samples; the worst work time is kept at it.
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Window length register write port.
    input  logic                   i_cfg_we,
    input  logic [CFG_W-1:0]       i_cfg_wdata,
    // Frame report channel.
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [SAMPLE_BITS-1:0] i_frame_ms,
    input  logic [SAMPLE_BITS-1:0] i_work_ms,
    // Window statistics channel.
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [ACC_W-1:0]       o_fps_tenths,
    output logic [ACC_W-1:0]       o_mean_frame_us,
    output logic [ACC_W-1:0]       o_mean_work_us,
    output logic [WORST_US_W-1:0]  o_worst_work_us,
    output logic [ACC_W-1:0]       o_frame_count
);

    // The controller sequences each frame report: it accumulates the report,
    // checks whether the window closed, and if so runs the three divides and
    // hands the results to the output register. The output register sits apart
    // from the working result registers, so new frame reports are taken while
    // a finished result transaction still waits for the consumer.
    t_dp_cmd cmd;
    t_dp_sts sts;

    wfts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // The datapath holds the window length, the accumulators, the scaling
    // multiplier, the shared bit-serial divider and the output register.
    wfts_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_frame_ms      (i_frame_ms),
        .i_work_ms       (i_work_ms),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_fps_tenths    (o_fps_tenths),
        .o_mean_frame_us (o_mean_frame_us),
        .o_mean_work_us  (o_mean_work_us),
        .o_worst_work_us (o_worst_work_us),
        .o_frame_count   (o_frame_count)
    );

endmodule

FILE: src/wfts_chk.sv
module wfts_chk
    import wfts_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [ACC_W-1:0]      o_fps_tenths,
    input logic [ACC_W-1:0]      o_frame_count,
    input logic [WORST_US_W-1:0] o_worst_work_us
);

    // A stalled result transaction keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_fps_tenths)
            && $stable(o_frame_count) && $stable(o_worst_work_us))
        else $error("result changed while stalled");

    // The block is busy in the cycle after an input transaction.
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted on consecutive cycles");

    // A result never appears right after an input transaction.
    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !$rose(o_out_valid))
        else $error("result appeared too early");

    // A new result is issued only as the block returns to accepting input.
    a_ready_on_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("result issued while busy");

endmodule

bind windowed_frame_time_stats_top wfts_chk u_wfts_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_fps_tenths    (o_fps_tenths),
    .o_frame_count   (o_frame_count),
    .o_worst_work_us (o_worst_work_us)
);
